### rtl/nep_pkg.sv
// shared types, constants and a helper function for the nal emulation prevention strip unit
package nep_pkg;

   // widths of the counters and result fields
   localparam int unsigned COUNT_W = 27;
   localparam int unsigned SODB_W  = 30;

   // byte cap of one unit (level 6.2)
   localparam logic [COUNT_W-1:0] MAX_NAL_BYTES = 27'd100000000;

   // emulation prevention byte value
   localparam logic [7:0] EPB_BYTE = 8'h03;

   // what the front decided for one input beat
   typedef enum logic [2:0] {
      KIND_HDR_HI,
      KIND_HDR_LO,
      KIND_EPB,
      KIND_KEEP,
      KIND_SKIP
   } nep_kind_type;

   // result error codes
   typedef enum logic [1:0] {
      ERR_OK         = 2'd0,
      ERR_SHORT      = 2'd1,
      ERR_NO_PAYLOAD = 2'd2
   } nep_err_type;

   // input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } nep_req_type;

   // result beat
   typedef struct packed {
      logic               out_valid;
      logic [7:0]         out_byte;
      logic [COUNT_W-1:0] out_index;
      logic               unit_done;
      logic [15:0]        nal_header;
      logic [SODB_W-1:0]  sodb_bits;
      logic [1:0]         error_code;
   } nep_rsp_type;

   // classified beat passed from front to back
   typedef struct packed {
      nep_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic         short_unit;
   } nep_cmd_type;

   // queue status
   typedef struct packed {
      logic       full;
      logic [1:0] level;
   } nep_q_status_type;

   // number of trailing zero bits of a byte, 8 for zero
   function automatic logic [3:0] low_zero_bits(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            n = 4'(i);
         end
      end
      return n;
   endfunction

endpackage

### rtl/nep_front.sv
// front part: accepts raw bytes, tracks position and zero run, classifies each beat
module nep_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  nep_pkg::nep_req_type      req_payload,
   input  nep_pkg::nep_q_status_type q_status,
   output logic                      push,
   output nep_pkg::nep_cmd_type      push_cmd
);
   import nep_pkg::*;

   logic [COUNT_W-1:0] raw_count_ff, raw_count_in;
   logic [1:0]         zero_run_ff, zero_run_in;
   logic               accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept;

   // classify the beat and work out the next position and zero run
   always_comb begin
      push_cmd.data       = req_payload.in_byte;
      push_cmd.last       = req_payload.last_byte;
      push_cmd.short_unit = (raw_count_ff == '0);
      push_cmd.kind       = KIND_SKIP;
      raw_count_in        = raw_count_ff;
      zero_run_in         = zero_run_ff;
      if (raw_count_ff < MAX_NAL_BYTES) begin
         raw_count_in = raw_count_ff + 1'b1;
         if (raw_count_ff == '0) begin
            push_cmd.kind = KIND_HDR_HI;
         end else if (raw_count_ff == COUNT_W'(1)) begin
            push_cmd.kind = KIND_HDR_LO;
         end else if (zero_run_ff >= 2'd2 && req_payload.in_byte == EPB_BYTE) begin
            push_cmd.kind = KIND_EPB;
            zero_run_in   = 2'd0;
         end else begin
            push_cmd.kind = KIND_KEEP;
            if (req_payload.in_byte != 8'd0) begin
               zero_run_in = 2'd0;
            end else if (zero_run_ff < 2'd2) begin
               zero_run_in = zero_run_ff + 2'd1;
            end
         end
      end
      // a final beat starts the next unit afresh
      if (req_payload.last_byte) begin
         raw_count_in = '0;
         zero_run_in  = 2'd0;
      end
   end

   // position and zero run registers
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_count_ff <= '0;
         zero_run_ff  <= 2'd0;
      end else if (accept) begin
         raw_count_ff <= raw_count_in;
         zero_run_ff  <= zero_run_in;
      end
   end

endmodule

### rtl/nep_queue.sv
// two-entry queue of classified beats between front and back
module nep_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  nep_pkg::nep_cmd_type      push_cmd,
   input  logic                      pop,
   output logic                      head_valid,
   output nep_pkg::nep_cmd_type      head_cmd,
   output nep_pkg::nep_q_status_type q_status
);
   import nep_pkg::*;

   nep_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  level_ff, level_in;
   logic        do_push, do_pop;

   assign do_push = push && (level_ff != 2'd2);
   assign do_pop  = pop && (level_ff != 2'd0);

   assign head_valid     = (level_ff != 2'd0);
   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (level_ff == 2'd2);
   assign q_status.level = level_ff;

   // pointer and level update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/nep_back.sv
// back part: carries out classified beats, tracks header and stop bit, drives result register
module nep_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  nep_pkg::nep_cmd_type head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nep_pkg::nep_rsp_type rsp_payload
);
   import nep_pkg::*;

   logic [COUNT_W-1:0] kept_count_ff, kept_count_in;
   logic [15:0]        header_ff, header_in;
   logic [COUNT_W-1:0] lnz_pos_ff, lnz_pos_in;
   logic [7:0]         lnz_value_ff, lnz_value_in;
   logic               seen_ff, seen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   nep_rsp_type        rsp_ff, rsp_in;

   assign pop          = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;
   assign rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // carry out one beat and form its result
   always_comb begin
      kept_count_in = kept_count_ff;
      header_in     = header_ff;
      lnz_pos_in    = lnz_pos_ff;
      lnz_value_in  = lnz_value_ff;
      seen_in       = seen_ff;
      rsp_in        = '0;
      case (head_cmd.kind)
         KIND_HDR_HI: begin
            header_in = {head_cmd.data, 8'h00};
         end
         KIND_HDR_LO: begin
            header_in = {header_ff[15:8], head_cmd.data};
         end
         KIND_KEEP: begin
            rsp_in.out_valid = 1'b1;
            rsp_in.out_byte  = head_cmd.data;
            rsp_in.out_index = kept_count_ff;
            kept_count_in    = kept_count_ff + 1'b1;
            if (head_cmd.data != 8'd0) begin
               lnz_pos_in   = kept_count_ff;
               lnz_value_in = head_cmd.data;
               seen_in      = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // end of unit summary, then clear for the next unit
      if (head_cmd.last) begin
         rsp_in.unit_done  = 1'b1;
         rsp_in.nal_header = header_in;
         if (head_cmd.short_unit) begin
            rsp_in.error_code = ERR_SHORT;
         end else if (!seen_in) begin
            rsp_in.error_code = ERR_NO_PAYLOAD;
         end else begin
            rsp_in.error_code = ERR_OK;
            rsp_in.sodb_bits  = SODB_W'({lnz_pos_in, 3'b000}) + SODB_W'(7)
                              - SODB_W'(low_zero_bits(lnz_value_in));
         end
         kept_count_in = '0;
         header_in     = 16'h0000;
         lnz_pos_in    = '0;
         lnz_value_in  = 8'd0;
         seen_in       = 1'b0;
      end
   end

   // unit state
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_count_ff <= '0;
         header_ff     <= 16'h0000;
         lnz_pos_ff    <= '0;
         lnz_value_ff  <= 8'd0;
         seen_ff       <= 1'b0;
      end else if (pop) begin
         kept_count_ff <= kept_count_in;
         header_ff     <= header_in;
         lnz_pos_ff    <= lnz_pos_in;
         lnz_value_ff  <= lnz_value_in;
         seen_ff       <= seen_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### rtl/nal_emulation_prevention_strip_unit.sv
// top level: nal unit emulation prevention byte stripper
// path: an accepted beat is written into a queue entry and popped into the result register once
//   that is free, and its result sits on rsp from then on, longer while rsp_ready holds it back
// throughput: one input beat per cycle while the queue is not full, one result beat per input
//   beat, set by the combinational classify step in the front and the result register in the back
// reset: synchronous, clears the queue, the unit counters and the result valid
module nal_emulation_prevention_strip_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nep_pkg::nep_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nep_pkg::nep_rsp_type rsp_payload
);
   import nep_pkg::*;

   logic             push, pop, head_valid;
   nep_cmd_type      push_cmd, head_cmd;
   nep_q_status_type q_status;

   // classify incoming beats
   nep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decoupling queue
   nep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .q_status   (q_status)
   );

   // carry out beats and drive results
   nep_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // queue level never goes past its two entries
   assert property (@(posedge clock) disable iff (reset) q_status.level != 2'd3)
      else $error("queue level out of range");

   // a beat into a full queue never happens
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("push into full queue");

   // a result that does not end a unit carries no error code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.unit_done |-> rsp_payload.error_code == ERR_OK)
      else $error("error code outside unit end");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
